FILE: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared types and constants
// Character codes, BCD adjust constants and the controller state type used by the converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } sitda_state_t;

endpackage

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter
// Converts one two's complement integer into its decimal text, one
// character per output transaction, most significant character first.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      slave      tdata: value (VALUE_WIDTH bits, signed)
//  out_     master     tdata: character (6 bits); tlast: final character
//
// An item passes through an accept step, VALUE_WIDTH shift-and-adjust steps of the
// bit-serial BCD converter, a minus sign step if negative and one step per
// decimal digit position (leading zeros are dropped one a cycle).
// Reset is synchronous and active low and returns the controller to idle.
// A stalled output holds the controller; a new value is taken once the last
// character has been loaded into the output register.
module signed_int_to_decimal_ascii_top
  import sitda_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [7:0]                             out_tdata,  // [5:0] character
  output logic                                   out_tlast
);

  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  sitda_state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]       mag_r, mag_nxt;
  logic [BCD_W-1:0]             bcd_r, bcd_nxt;
  logic [BCD_W-1:0]             bcd_adj;
  logic [BIT_CNT_W-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]         dig_cnt_r, dig_cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic                         started_r, started_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]            out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_free;
  logic [3:0]                   top_digit;
  logic [VALUE_WIDTH-1:0]       in_value;
  logic                         in_neg;

  assign in_value  = in_tdata[VALUE_WIDTH-1:0];
  assign in_neg    = in_value[VALUE_WIDTH-1];
  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_char_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= BCD_ADJ_LIMIT) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    neg_r      <= neg_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt     = in_neg;
          mag_nxt     = in_neg ? (~in_value + 1'b1) : in_value;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
        mag_nxt     = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (top_digit == 4'd0 && !started_r && dig_cnt_r != DIG_CNT_W'(1)) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {2'b00, top_digit};
          out_last_nxt  = (dig_cnt_r == DIG_CNT_W'(1));
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
          started_nxt   = 1'b1;
          if (dig_cnt_r == DIG_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[5:0] == CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign flagged as final character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] == CHAR_MINUS ||
                    (out_tdata[5:0] >= CHAR_ZERO && out_tdata[5:0] <= CHAR_ZERO + 6'd9)))
    else $error("character outside the decimal text set");

  a_digits_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGITS) |-> (dig_cnt_r != '0))
    else $error("digit phase entered with no digits left");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CONV && bit_cnt_r == '0))
    else $error("accepted transaction did not start the conversion");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the signed integer to decimal ASCII converter
// Sends two's complement integers and checks each returned character and its
// end-of-text flag against texts predicted inside the bench. It covers edge
// values, random values of every length, uneven idling on both channels and a
// long output hold-off that stalls the input.
// ----------------------------------------------------------------------------
module tb
  import sitda_pkg::*;
();

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX = 10;
  localparam int MAX_REPORTS = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [VALUE_WIDTH-1:0] in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [7:0]             out_tdata;
  logic                   out_tlast;

  text_char_t expected_text[$];
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic       rx_hold_req = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_left = 0;
  int         mismatch_count = 0;
  int         values_sent = 0;
  int         chars_checked = 0;
  int         quiet_cycles = 0;

  signed_int_to_decimal_ascii_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value);
    bit [VALUE_WIDTH-1:0] magnitude;
    logic [CHAR_W-1:0]    digits[24];
    int                   n;
    magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    n = 0;
    do begin
      digits[n] = CHAR_ZERO + CHAR_W'(magnitude % RADIX);
      magnitude = magnitude / RADIX;
      n++;
    end while (magnitude != 0);
    if (value[VALUE_WIDTH-1]) begin
      expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
    end
    for (int k = n - 1; k >= 0; k--) begin
      expected_text.push_back('{code: digits[k], last: (k == 0)});
    end
  endfunction

  // Three calls in four pick a digit count first, all counts equally likely.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    longint lo;
    longint hi;
    longint magnitude;
    int     digits;
    bit     negative;
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    digits = $urandom_range(1, 10);
    negative = 1'($urandom_range(1));
    lo = 1;
    repeat (digits - 1) lo = lo * RADIX;
    hi = lo * RADIX - 1;
    if (digits == 1) begin
      lo = 0;
    end
    if (hi > 64'sd2147483647) begin
      hi = negative ? 64'sd2147483648 : 64'sd2147483647;
    end
    magnitude = lo + longint'($urandom) % (hi - lo + 1);
    return negative ? VALUE_WIDTH'(-magnitude) : VALUE_WIDTH'(magnitude);
  endfunction

  task automatic record_failure(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_text(value);
    values_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (rx_hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(negedge clk) begin
    text_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        record_failure($sformatf("unexpected character %0d last %0b",
                                 out_tdata[CHAR_W-1:0], out_tlast));
      end else begin
        want = expected_text.pop_front();
        if (out_tdata[CHAR_W-1:0] !== want.code || out_tlast !== want.last) begin
          record_failure($sformatf("character %0d last %0b, expected %0d last %0b",
                                   out_tdata[CHAR_W-1:0], out_tlast,
                                   want.code, want.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No transaction for %0d cycles, %0d characters outstanding.",
                 STALL_LIMIT, expected_text.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_edge_values();
    logic [VALUE_WIDTH-1:0] edge_values[$];
    edge_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                    32'd100, -32'sd5, 32'd999999999, -32'sd999999999,
                    32'd1000000000, 32'd1234567890, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                    32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    foreach (edge_values[i]) begin
      send_value(edge_values[i]);
    end
  endtask

  task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (count) send_value(pick_value());
  endtask

  // The receiver stops for a long stretch while values keep coming, so the
  // converter stalls on its output and has to hold its input off.
  task automatic test_output_hold_off();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    rx_hold_req <= 1'b1;
    repeat (24) send_value(pick_value());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_random_traffic(110, 36, 85);
    test_random_traffic(110, 85, 36);
    test_random_traffic(90, 0, 0);
    test_output_hold_off();

    in_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d characters, with edge values, three idle",
             values_sent, chars_checked);
    $display("patterns on the two channels and one long output hold-off.");
    if (expected_text.size() != 0) begin
      record_failure($sformatf("%0d characters never arrived", expected_text.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failures in total.", mismatch_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sitda_pkg.sv
rtl/signed_int_to_decimal_ascii_top.sv
sim/tb.sv
